### rtl/core/ttsc_pkg.sv
// ----------------------------------------------------------------------------
// ttsc_pkg
// Shared types and constants of the touch tap and swipe classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ttsc_pkg;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 12;
   localparam int OUT_COORD_W = 12;
   localparam int THRESH_W = 12;

   localparam logic [7:0] STATUS_NO_TOUCH = 8'hFF;
   localparam logic [7:0] COUNT_ONE = 8'd1;
   localparam logic [7:0] COUNT_TWO = 8'd2;

   localparam logic [THRESH_W-1:0] SWIPE_MIN_RESET = 12'd60;
   localparam logic [THRESH_W-1:0] TAP_MAX_RESET = 12'd25;

   localparam logic signed [1:0] SWIPE_NONE = 2'sd0;
   localparam logic signed [1:0] SWIPE_RIGHT = 2'sd1;
   localparam logic signed [1:0] SWIPE_LEFT = -2'sd1;

   typedef enum logic [1:0] {
      CSR_DEVICE_PRESENT = 2'd0,
      CSR_SWIPE_MIN = 2'd1,
      CSR_TAP_MAX = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic device_present;
      logic [THRESH_W-1:0] swipe_min;
      logic [THRESH_W-1:0] tap_max;
   } cfg_type;

   typedef struct packed {
      logic swipe_ack;
      logic [7:0] y_low;
      logic [7:0] y_high;
      logic [7:0] x_low;
      logic [7:0] x_high;
      logic [7:0] point_count;
      logic [7:0] status_byte;
      logic read_ok;
   } sample_type;

   typedef struct packed {
      logic finger_down;
      logic signed [1:0] swipe_dir;
      logic [OUT_COORD_W-1:0] raw_y;
      logic [OUT_COORD_W-1:0] raw_x;
      logic [OUT_COORD_W-1:0] tap_y;
      logic [OUT_COORD_W-1:0] tap_x;
      logic tapped;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/ttsc_track.sv
// ----------------------------------------------------------------------------
// ttsc_track
// Press tracking state and release classification, one poll per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ttsc_track
   import ttsc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire sample_type sample,
   input  wire cfg_type    cfg,
   output result_type      result
);

   localparam int CMP_W = (COORD_BITS > THRESH_W) ? COORD_BITS : THRESH_W;

   logic                   pressed_ff, pressed_in;
   logic [COORD_BITS-1:0]  start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [COORD_BITS-1:0]  last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [COORD_BITS-1:0]  raw_x_ff, raw_x_in, raw_y_ff, raw_y_in;
   logic [COORD_BITS-1:0]  tap_x_ff, tap_x_in, tap_y_ff, tap_y_in;
   logic signed [1:0]      latch_ff, latch_in;

   logic                   down;
   logic                   tapped;
   logic [COORD_BITS-1:0]  px, py, adx, ady;
   logic                   is_swipe, is_tap;

   always_comb begin
      down = cfg.device_present && sample.read_ok
             && (sample.status_byte != STATUS_NO_TOUCH)
             && ((sample.point_count == COUNT_ONE) || (sample.point_count == COUNT_TWO));
      px = COORD_BITS'({sample.x_high[3:0], sample.x_low});
      py = COORD_BITS'({sample.y_high[3:0], sample.y_low});
      adx = (last_x_ff >= start_x_ff) ? last_x_ff - start_x_ff : start_x_ff - last_x_ff;
      ady = (last_y_ff >= start_y_ff) ? last_y_ff - start_y_ff : start_y_ff - last_y_ff;
      is_swipe = (CMP_W'(adx) >= CMP_W'(cfg.swipe_min)) && (adx > ady);
      is_tap = (CMP_W'(adx) < CMP_W'(cfg.tap_max)) && (CMP_W'(ady) < CMP_W'(cfg.tap_max));

      pressed_in = pressed_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      raw_x_in = raw_x_ff;
      raw_y_in = raw_y_ff;
      tap_x_in = tap_x_ff;
      tap_y_in = tap_y_ff;
      latch_in = sample.swipe_ack ? SWIPE_NONE : latch_ff;
      tapped = 1'b0;

      if (down) begin
         raw_x_in = px;
         raw_y_in = py;
         last_x_in = px;
         last_y_in = py;
         pressed_in = 1'b1;
         if (!pressed_ff) begin
            start_x_in = px;
            start_y_in = py;
         end
      end else if (pressed_ff) begin
         pressed_in = 1'b0;
         if (is_swipe) begin
            latch_in = (last_x_ff > start_x_ff) ? SWIPE_RIGHT : SWIPE_LEFT;
         end else if (is_tap) begin
            tapped = 1'b1;
            tap_x_in = last_x_ff;
            tap_y_in = last_y_ff;
         end
      end

      result.tapped = tapped;
      result.tap_x = OUT_COORD_W'(tap_x_in);
      result.tap_y = OUT_COORD_W'(tap_y_in);
      result.raw_x = OUT_COORD_W'(raw_x_in);
      result.raw_y = OUT_COORD_W'(raw_y_in);
      result.swipe_dir = latch_in;
      result.finger_down = pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= 1'b0;
         start_x_ff <= '0;
         start_y_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         raw_x_ff <= '0;
         raw_y_ff <= '0;
         tap_x_ff <= '0;
         tap_y_ff <= '0;
         latch_ff <= SWIPE_NONE;
      end else if (step) begin
         pressed_ff <= pressed_in;
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         raw_x_ff <= raw_x_in;
         raw_y_ff <= raw_y_in;
         tap_x_ff <= tap_x_in;
         tap_y_ff <= tap_y_in;
         latch_ff <= latch_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/touch_tap_swipe_classifier_unit.sv
// ----------------------------------------------------------------------------
// touch_tap_swipe_classifier_unit
// Classifies touch controller polls into presses, taps and swipes.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                   Transfer
// req_      in   one controller poll (56-bit tdata)        tvalid && tready
// rsp_      out  one classification result (56-bit tdata)  tvalid && tready
// csr_      in   register write (index, 12-bit data)       csr_we
//
// One poll per cycle while req_tready is high; each result is registered in
// the output entries from the single pass through the tracking logic.
// A two-entry output (result register plus skid) keeps req_tready high while
// one result waits; req_tready drops only when both entries are full.
// Synchronous reset clears tracking state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_tap_swipe_classifier_unit
   import ttsc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // read_ok, status_byte, point_count, x_high, x_low, y_high, y_low,
   // swipe_ack, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tapped, tap_x, tap_y, raw_x, raw_y, swipe_dir, finger_down, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   sample_type sample;
   result_type result;
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;
   logic       req_xfer, rsp_xfer;

   assign sample = req_tdata[$bits(sample_type)-1:0];
   assign req_tready = !skid_valid_ff;
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_xfer = out_valid_ff && rsp_tready;
   assign rsp_tdata = RSP_DATA_W'(out_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_present <= 1'b0;
         cfg_ff.swipe_min <= SWIPE_MIN_RESET;
         cfg_ff.tap_max <= TAP_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_PRESENT: cfg_ff.device_present <= csr_wdata[0];
            CSR_SWIPE_MIN:      cfg_ff.swipe_min <= csr_wdata;
            CSR_TAP_MAX:        cfg_ff.tap_max <= csr_wdata;
            default: ;
         endcase
      end
   end

   ttsc_track #(
      .COORD_BITS(COORD_BITS)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (req_xfer),
      .sample (sample),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            out_ff <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer) begin
         if (!out_valid_ff || rsp_xfer) begin
            out_ff <= result;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff <= result;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         out_valid_ff <= 1'b0;
      end
   end

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> (out_valid_ff && !req_tready))
      else $error("skid entry held without a pending result");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !out_valid_ff) |=> rsp_tvalid)
      else $error("accepted poll produced no result");

   a_tap_ends_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.tapped) |-> !out_ff.finger_down)
      else $error("tap reported while finger still down");
`endif

endmodule

`default_nettype wire
